// ===== sv/dtdac_pkg.sv =====
// Package with widths, constants, state type and power-of-ten tables for the DAC code converter.
package dtdac_pkg;

  // Field widths.
  localparam int unsigned CharW     = 8;
  localparam int unsigned CodeW     = 12;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 16;

  // Datapath widths.
  localparam int unsigned MagW   = 4;
  localparam int unsigned FracW  = 17;
  localparam int unsigned FcntW  = 3;
  localparam int unsigned WertW  = 21;
  localparam int unsigned DenW   = 19;
  localparam int unsigned RemW   = WertW + 10;
  localparam int unsigned QcntW  = 4;

  // Parameter defaults.
  localparam int unsigned MaxCharsDef     = 12;
  localparam int unsigned MaxFracDigitsDef = 5;

  // Character codes.
  localparam logic [CharW-1:0] ChPoint = 8'h2E;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Magnitude limits and result codes.
  localparam logic [MagW-1:0]  MagClip  = 4'd10;
  localparam logic [MagW-1:0]  MagMax   = 4'd9;
  localparam logic [CodeW-1:0] CodeFull = 12'hFFF;
  localparam logic [CodeW-1:0] CodeZero = 12'h000;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FIN
  } dtdac_state_e;

  // Ten to the power of the kept fraction digit count.
  function automatic logic [FracW-1:0] pow10(input logic [FcntW-1:0] k);
    logic [FracW-1:0] p;
    unique case (k)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // Divisor five times ten to the k.
  function automatic logic [DenW-1:0] den5(input logic [FcntW-1:0] k);
    logic [DenW-1:0] p;
    unique case (k)
      3'd0:    p = 19'd5;
      3'd1:    p = 19'd50;
      3'd2:    p = 19'd500;
      3'd3:    p = 19'd5000;
      3'd4:    p = 19'd50000;
      3'd5:    p = 19'd500000;
      default: p = 19'd5;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/decimal_text_to_dac_code.sv =====
// Top level: parses a decimal voltage text and converts it to a 12-bit DAC code.
// Non-final characters are accepted back to back. The final character starts a sequence of
// a setup state, a shared compare-and-subtract divider that yields one quotient bit per step
// for all 12 code bits, and a load state; a clipped text skips the divider. The input is not
// ready until the code is loaded, and a stalled result output holds the load state.
// Reset (asynchronous, active low) clears the parse state, the sequencer and output valid.
module decimal_text_to_dac_code
  import dtdac_pkg::*;
#(
  parameter int unsigned MAX_CHARS       = MaxCharsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataInW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                 s_axis_tlast,   // last_char
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata,   // [11:0] dac_code, [15:12] zero
  output logic                 m_axis_tuser    // [0] clipped
);

  localparam int unsigned IdxW = $clog2(MAX_CHARS + 1);
  localparam logic [IdxW-1:0]  MaxIdx  = IdxW'(MAX_CHARS);
  localparam logic [FcntW-1:0] MaxFrac = FcntW'(MAX_FRAC_DIGITS);
  localparam logic [QcntW-1:0] QLast   = QcntW'(CodeW - 1);

  dtdac_state_e state_q, state_d;

  logic             neg_q, neg_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic             icl_q, icl_d;
  logic             pnt_q, pnt_d;
  logic [FracW-1:0] fv_q, fv_d;
  logic [FcntW-1:0] fc_q, fc_d;
  logic             fcl_q, fcl_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [RemW-1:0]  rem_q, rem_d;
  logic [RemW-1:0]  dsh_q, dsh_d;
  logic [CodeW-1:0] quo_q, quo_d;
  logic [QcntW-1:0] qcnt_q, qcnt_d;
  logic [CodeW-1:0] res_q, res_d;
  logic             clip_q, clip_d;

  logic             ovalid_q, ovalid_d;
  logic [CodeW-1:0] ocode_q, ocode_d;
  logic             oclip_q, oclip_d;

  logic in_acc;
  logic out_free;
  logic is_clip;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign is_clip  = (mag_q > MagMax);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tlast) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = is_clip ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (qcnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = ovalid_q;
    m_axis_tdata  = {{(TdataOutW - CodeW){1'b0}}, ocode_q};
    m_axis_tuser  = oclip_q;
  end

  // Character parser: update of the text state for one accepted character.
  always_comb begin
    logic             digit;
    logic [3:0]       dval;
    logic             point;
    logic [6:0]       iv;
    logic [FracW+2:0] fvx;

    digit = (s_axis_tdata >= ChZero) && (s_axis_tdata <= ChNine);
    dval  = s_axis_tdata[3:0];
    point = (s_axis_tdata == ChPoint) || (s_axis_tdata == ChComma);
    iv    = {mag_q, 3'b000} + {2'b00, mag_q, 1'b0} + {3'b000, dval};
    fvx   = {fv_q, 3'b000} + {2'b00, fv_q, 1'b0} + {{(FracW - 1){1'b0}}, dval};

    neg_d = neg_q;
    mag_d = mag_q;
    icl_d = icl_q;
    pnt_d = pnt_q;
    fv_d  = fv_q;
    fc_d  = fc_q;
    fcl_d = fcl_q;
    idx_d = idx_q;

    if (state_q == ST_IDLE) begin
      if (in_acc && (idx_q < MaxIdx)) begin
        idx_d = idx_q + 1'b1;
        if (point) begin
          icl_d = 1'b1;
          pnt_d = 1'b1;
          fv_d  = '0;
          fc_d  = '0;
          fcl_d = 1'b0;
        end else begin
          // Integer run: leading digits after an optional sign.
          if (!icl_q) begin
            if (digit) begin
              mag_d = (iv > 7'd9) ? MagClip : iv[MagW-1:0];
            end else if ((s_axis_tdata == ChMinus) && (idx_q == '0)) begin
              neg_d = 1'b1;
            end else begin
              icl_d = 1'b1;
            end
          end
          // Fraction run after the last point.
          if (pnt_q && !fcl_q) begin
            if (digit) begin
              if (fc_q < MaxFrac) begin
                fv_d = fvx[FracW-1:0];
                fc_d = fc_q + 1'b1;
              end
            end else begin
              fcl_d = 1'b1;
            end
          end
        end
      end
    end else if ((state_q == ST_FIN) && out_free) begin
      // Text done: back to the empty state.
      neg_d = 1'b0;
      mag_d = '0;
      icl_d = 1'b0;
      pnt_d = 1'b0;
      fv_d  = '0;
      fc_d  = '0;
      fcl_d = 1'b0;
      idx_d = '0;
    end
  end

  // Setup of the dividend and the shared divider steps.
  always_comb begin
    logic [FracW-1:0]  pot;
    logic [4:0]        fac;
    logic [WertW:0]    prod;
    logic [WertW-1:0]  wert;
    logic [RemW-1:0]   diff;
    logic              ge;

    pot  = pow10(fc_q);
    fac  = neg_q ? (5'd10 - {1'b0, mag_q}) : (5'd10 + {1'b0, mag_q});
    prod = (WertW + 1)'(fac * pot);
    wert = neg_q ? WertW'(prod - {{(WertW + 1 - FracW){1'b0}}, fv_q})
                 : WertW'(prod + {{(WertW + 1 - FracW){1'b0}}, fv_q});
    ge   = (rem_q >= dsh_q);
    diff = rem_q - dsh_q;

    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    qcnt_d = qcnt_q;
    res_d  = res_q;
    clip_d = clip_q;

    unique case (state_q)
      ST_CALC: begin
        rem_d  = {wert, 10'b0};
        dsh_d  = {1'b0, den5(fc_q), 11'b0};
        quo_d  = '0;
        qcnt_d = QLast;
        clip_d = is_clip;
        res_d  = neg_q ? CodeZero : CodeFull;
      end
      ST_DIV: begin
        // One quotient bit per cycle, most significant first.
        if (ge) begin
          rem_d = diff;
        end
        quo_d  = {quo_q[CodeW-2:0], ge};
        dsh_d  = dsh_q >> 1;
        qcnt_d = qcnt_q - 1'b1;
        if (qcnt_q == '0) begin
          res_d = {quo_q[CodeW-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a result until it is taken.
  always_comb begin
    ovalid_d = ovalid_q;
    ocode_d  = ocode_q;
    oclip_d  = oclip_q;
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    if ((state_q == ST_FIN) && out_free) begin
      ovalid_d = 1'b1;
      ocode_d  = res_q;
      oclip_d  = clip_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      icl_q    <= 1'b0;
      pnt_q    <= 1'b0;
      fv_q     <= '0;
      fc_q     <= '0;
      fcl_q    <= 1'b0;
      idx_q    <= '0;
      qcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      icl_q    <= icl_d;
      pnt_q    <= pnt_d;
      fv_q     <= fv_d;
      fc_q     <= fc_d;
      fcl_q    <= fcl_d;
      idx_q    <= idx_d;
      qcnt_q   <= qcnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    res_q   <= res_d;
    clip_q  <= clip_d;
    ocode_q <= ocode_d;
    oclip_q <= oclip_d;
  end

endmodule
